/* rtl/sfm_pkg.sv */
// shared constants, types and modular helpers for the sm2 signature finish
package sfm_pkg;

	localparam int unsigned W = 256;
	localparam int unsigned LIMB_W = 64;
	localparam int unsigned NUM_LIMBS = 4;
	localparam int unsigned NUM_CELLS = 4;
	localparam int unsigned CELL_BITS = 64;
	localparam int unsigned CNT_W = 7;

	localparam logic [W-1:0] ORD_N =
		256'hFFFFFFFEFFFFFFFFFFFFFFFFFFFFFFFF7203DF6B21C6052B53BBF40939D54123;

	localparam logic [2:0] REG_KEY_W0 = 3'd0;
	localparam logic [2:0] REG_KEY_W1 = 3'd1;
	localparam logic [2:0] REG_KEY_W2 = 3'd2;
	localparam logic [2:0] REG_KEY_W3 = 3'd3;

	typedef struct packed {
		logic [W-1:0] acc;
		logic [W-1:0] a;
		logic [W-1:0] r;
	} item_t;

	// one conditional subtraction of n
	function automatic logic [W-1:0] reduce_once(input logic [W-1:0] x);
		logic [W:0] d;
		begin
			d = {1'b0, x} - {1'b0, ORD_N};
			reduce_once = d[W] ? x : d[W-1:0];
		end
	endfunction

	// a + b mod n, both below n
	function automatic logic [W-1:0] mod_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		logic [W+1:0] d;
		begin
			s = {1'b0, a} + {1'b0, b};
			d = {1'b0, s} - {2'b00, ORD_N};
			mod_add = d[W+1] ? s[W-1:0] : d[W-1:0];
		end
	endfunction

	// a - b mod n, both below n
	function automatic logic [W-1:0] mod_sub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] d;
		begin
			d = {1'b0, a} - {1'b0, b};
			mod_sub = d[W] ? (d[W-1:0] + ORD_N) : d[W-1:0];
		end
	endfunction

endpackage

/* rtl/sm2_signature_finish_modn.sv */
// top level: operand reduction, chain of multiplier cells, final subtraction
//
// Usage: pulse start with digest, nonce and point x (four 64-bit limbs each)
// while busy is low; the word is taken at that edge. The key value d' is
// written through cfg_valid/cfg_ready/cfg_index/cfg_data, index 0..3 for
// limbs w0..w3; the user must write it only while the block is idle, as
// the block does not enforce this: cfg_ready is always high. A result
// word (r, s) appears on the sig ports with done, which is high for one cycle.
// The word passes four front stages of operand reduction and additions,
// then four cells, each of 64 double-and-add steps over one key limb and
// a hand-off to the next; the final subtraction and done are registered.
// A new word is taken once the front stages are empty and the first cell
// is idle. Up to four words are in the cell chain at once.
// Reset clears all valid flags and the key to zero. The receiver cannot
// stall: done is a one-cycle strobe and the result must be taken then.
module sm2_signature_finish_modn
	import sfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       digest_w0,
	input  logic [63:0]       digest_w1,
	input  logic [63:0]       digest_w2,
	input  logic [63:0]       digest_w3,
	input  logic [63:0]       nonce_w0,
	input  logic [63:0]       nonce_w1,
	input  logic [63:0]       nonce_w2,
	input  logic [63:0]       nonce_w3,
	input  logic [63:0]       point_x_w0,
	input  logic [63:0]       point_x_w1,
	input  logic [63:0]       point_x_w2,
	input  logic [63:0]       point_x_w3,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output logic              done,
	output logic [63:0]       sig_r_w0,
	output logic [63:0]       sig_r_w1,
	output logic [63:0]       sig_r_w2,
	output logic [63:0]       sig_r_w3,
	output logic [63:0]       sig_s_w0,
	output logic [63:0]       sig_s_w1,
	output logic [63:0]       sig_s_w2,
	output logic [63:0]       sig_s_w3
);

	logic [LIMB_W-1:0] key_q [NUM_LIMBS];
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [W-1:0]      e_s1, k_s1, x_s1;
	logic [W-1:0]      e_s2, k_s2, x_s2;
	logic [W-1:0]      k_s3, r_s3;
	logic [W-1:0]      t_s4, r_s4;
	logic              take;
	logic              done_q;
	logic [W-1:0]      r_q, s_q;

	logic              c_vld [NUM_CELLS+1];
	logic              c_rdy [NUM_CELLS+1];
	item_t             c_itm [NUM_CELLS+1];

	assign cfg_ready = 1'b1;
	assign take = start && !busy;
	assign busy = v_s1 || v_s2 || v_s3 || v_s4 || !c_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LIMBS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_W0: key_q[0] <= cfg_data;
				REG_KEY_W1: key_q[1] <= cfg_data;
				REG_KEY_W2: key_q[2] <= cfg_data;
				REG_KEY_W3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// front pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				v_s4 <= 1'b1;
			end else if (c_rdy[0]) begin
				v_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			e_s1 <= {digest_w3, digest_w2, digest_w1, digest_w0};
			k_s1 <= {nonce_w3, nonce_w2, nonce_w1, nonce_w0};
			x_s1 <= {point_x_w3, point_x_w2, point_x_w1, point_x_w0};
		end
		e_s2 <= reduce_once(e_s1);
		k_s2 <= reduce_once(k_s1);
		x_s2 <= reduce_once(x_s1);
		k_s3 <= k_s2;
		r_s3 <= mod_add(e_s2, x_s2);
		if (v_s3) begin
			t_s4 <= mod_add(k_s3, r_s3);
			r_s4 <= r_s3;
		end
	end

	assign c_vld[0]     = v_s4;
	assign c_itm[0].acc = '0;
	assign c_itm[0].a   = t_s4;
	assign c_itm[0].r   = r_s4;
	assign c_rdy[NUM_CELLS] = 1'b1;

	// cell j works on the key limb holding bits from the top down
	for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
		sfm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key_limb  (key_q[NUM_CELLS-1-j]),
			.in_valid  (c_vld[j]),
			.in_ready  (c_rdy[j]),
			.in_item   (c_itm[j]),
			.out_valid (c_vld[j+1]),
			.out_ready (c_rdy[j+1]),
			.out_item  (c_itm[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= c_vld[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (c_vld[NUM_CELLS]) begin
			r_q <= c_itm[NUM_CELLS].r;
			s_q <= mod_sub(c_itm[NUM_CELLS].acc, c_itm[NUM_CELLS].r);
		end
	end

	assign done     = done_q;
	assign sig_r_w0 = r_q[63:0];
	assign sig_r_w1 = r_q[127:64];
	assign sig_r_w2 = r_q[191:128];
	assign sig_r_w3 = r_q[255:192];
	assign sig_s_w0 = s_q[63:0];
	assign sig_s_w1 = s_q[127:64];
	assign sig_s_w2 = s_q[191:128];
	assign sig_s_w3 = s_q[255:192];

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy)
		else $error("accepted word not marked busy");
	a_r_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (r_q < ORD_N && s_q < ORD_N))
		else $error("result not reduced");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

endmodule

/* rtl/sfm_cell.sv */
// one multiplier cell: 64 double-and-add steps over one key limb
module sfm_cell
	import sfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LIMB_W-1:0] key_limb,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output item_t             out_item
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	item_t            item_q;
	logic             fin;
	logic             kbit;
	logic [W+1:0]     dbl;
	logic [W+2:0]     d1;
	logic [W+2:0]     d2;
	logic [W-1:0]     nxt;

	assign fin       = cnt_q[CNT_W-1];
	assign in_ready  = !busy_q;
	assign out_valid = busy_q && fin;
	assign out_item  = item_q;
	assign kbit      = key_limb[~cnt_q[5:0]];

	always_comb begin
		dbl = {1'b0, item_q.acc, 1'b0} + (kbit ? {2'b00, item_q.a} : '0);
		d1  = {1'b0, dbl} - {3'b000, ORD_N};
		d2  = {1'b0, dbl} - {2'b00, ORD_N, 1'b0};
		priority if (!d2[W+2]) begin
			nxt = d2[W-1:0];
		end else if (!d1[W+2]) begin
			nxt = d1[W-1:0];
		end else begin
			nxt = dbl[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (!fin) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			item_q <= in_item;
		end else if (busy_q && !fin) begin
			item_q.acc <= nxt;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= CNT_W'(CELL_BITS)))
		else $error("cell step count overran");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !fin) |=> (busy_q && cnt_q == $past(cnt_q) + 1'b1))
		else $error("cell step lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(item_q)))
		else $error("finished word not held");

endmodule

/* tb/sv/sfm_checker.sv */
// predictor and scoreboard for the sm2 signature finish block
`timescale 1ns / 1ps
module sfm_checker
	import sfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] digest_w0,
	input  logic [63:0] digest_w1,
	input  logic [63:0] digest_w2,
	input  logic [63:0] digest_w3,
	input  logic [63:0] nonce_w0,
	input  logic [63:0] nonce_w1,
	input  logic [63:0] nonce_w2,
	input  logic [63:0] nonce_w3,
	input  logic [63:0] point_x_w0,
	input  logic [63:0] point_x_w1,
	input  logic [63:0] point_x_w2,
	input  logic [63:0] point_x_w3,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        done,
	input  logic [63:0] sig_r_w0,
	input  logic [63:0] sig_r_w1,
	input  logic [63:0] sig_r_w2,
	input  logic [63:0] sig_r_w3,
	input  logic [63:0] sig_s_w0,
	input  logic [63:0] sig_s_w1,
	input  logic [63:0] sig_s_w2,
	input  logic [63:0] sig_s_w3,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [255:0] r;
		logic [255:0] s;
	} sig_pair_t;

	logic [255:0] key_inv;
	sig_pair_t    sig_queue[$];

	function automatic logic [255:0] fold_n(input logic [255:0] v);
		fold_n = (v >= ORD_N) ? v - ORD_N : v;
	endfunction

	function automatic sig_pair_t sign_pair(input logic [255:0] e, input logic [255:0] k,
			input logic [255:0] x, input logic [255:0] d);
		logic [256:0] t;
		logic [511:0] p;
		logic [255:0] m;
		sig_pair_t    res;
		t = {1'b0, fold_n(e)} + {1'b0, fold_n(x)};
		if (t >= {1'b0, ORD_N})
			t = t - {1'b0, ORD_N};
		res.r = t[255:0];
		t = {1'b0, fold_n(k)} + {1'b0, res.r};
		if (t >= {1'b0, ORD_N})
			t = t - {1'b0, ORD_N};
		p = {256'd0, t[255:0]} * {256'd0, d};
		p = p % {256'd0, ORD_N};
		m = p[255:0];
		res.s = (m >= res.r) ? m - res.r : m + (ORD_N - res.r);
		return res;
	endfunction

	assign pending = sig_queue.size();

	always @(posedge clk or negedge arst_n) begin
		sig_pair_t want;
		logic [255:0] got_r;
		logic [255:0] got_s;
		if (!arst_n) begin
			key_inv <= '0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_W0: key_inv[63:0]    <= cfg_data;
					REG_KEY_W1: key_inv[127:64]  <= cfg_data;
					REG_KEY_W2: key_inv[191:128] <= cfg_data;
					REG_KEY_W3: key_inv[255:192] <= cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				got_r = {sig_r_w3, sig_r_w2, sig_r_w1, sig_r_w0};
				got_s = {sig_s_w3, sig_s_w2, sig_s_w1, sig_s_w0};
				if (sig_queue.size() == 0) begin
					$display("%0t: result word with none expected: r=%h s=%h",
						$time, got_r, got_s);
					errors++;
				end else begin
					want = sig_queue.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (want.r[i*64 +: 64] !== got_r[i*64 +: 64]) begin
							$display("%0t: sig_r_w%0d expected %h actual %h", $time, i,
								want.r[i*64 +: 64], got_r[i*64 +: 64]);
							errors++;
						end
						if (want.s[i*64 +: 64] !== got_s[i*64 +: 64]) begin
							$display("%0t: sig_s_w%0d expected %h actual %h", $time, i,
								want.s[i*64 +: 64], got_s[i*64 +: 64]);
							errors++;
						end
					end
				end
			end
			if (start && !busy)
				sig_queue.push_back(sign_pair(
					{digest_w3, digest_w2, digest_w1, digest_w0},
					{nonce_w3, nonce_w2, nonce_w1, nonce_w0},
					{point_x_w3, point_x_w2, point_x_w1, point_x_w0}, key_inv));
		end
	end

endmodule

/* tb/sv/testbench.sv */
// stimulus and verdict for the sm2 signature finish block
`timescale 1ns / 1ps
module testbench;
	import sfm_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [255:0] e_in = '0;
	logic [255:0] k_in = '0;
	logic [255:0] x_in = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_KEY_W0;
	logic [63:0] cfg_data = '0;
	logic        done;
	logic [63:0] r_w[4];
	logic [63:0] s_w[4];
	int          errors;
	int          pending;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;

	always #4 clk = ~clk;

	sm2_signature_finish_modn i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.digest_w0(e_in[63:0]), .digest_w1(e_in[127:64]),
		.digest_w2(e_in[191:128]), .digest_w3(e_in[255:192]),
		.nonce_w0(k_in[63:0]), .nonce_w1(k_in[127:64]),
		.nonce_w2(k_in[191:128]), .nonce_w3(k_in[255:192]),
		.point_x_w0(x_in[63:0]), .point_x_w1(x_in[127:64]),
		.point_x_w2(x_in[191:128]), .point_x_w3(x_in[255:192]),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done),
		.sig_r_w0(r_w[0]), .sig_r_w1(r_w[1]), .sig_r_w2(r_w[2]), .sig_r_w3(r_w[3]),
		.sig_s_w0(s_w[0]), .sig_s_w1(s_w[1]), .sig_s_w2(s_w[2]), .sig_s_w3(s_w[3])
	);

	sfm_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.digest_w0(e_in[63:0]), .digest_w1(e_in[127:64]),
		.digest_w2(e_in[191:128]), .digest_w3(e_in[255:192]),
		.nonce_w0(k_in[63:0]), .nonce_w1(k_in[127:64]),
		.nonce_w2(k_in[191:128]), .nonce_w3(k_in[255:192]),
		.point_x_w0(x_in[63:0]), .point_x_w1(x_in[127:64]),
		.point_x_w2(x_in[191:128]), .point_x_w3(x_in[255:192]),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done),
		.sig_r_w0(r_w[0]), .sig_r_w1(r_w[1]), .sig_r_w2(r_w[2]), .sig_r_w3(r_w[3]),
		.sig_s_w0(s_w[0]), .sig_s_w1(s_w[1]), .sig_s_w2(s_w[2]), .sig_s_w3(s_w[3]),
		.errors(errors), .pending(pending)
	);

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [255:0] rand_wide();
		return {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	// biased towards zero, all ones and the neighbourhood of n
	function automatic logic [255:0] pick_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return ORD_N - 256'($urandom_range(3));
			3: return ORD_N + 256'($urandom_range(3));
			default: return rand_wide();
		endcase
	endfunction

	task automatic send_word(input logic [255:0] e, input logic [255:0] k,
			input logic [255:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		e_in <= e;
		k_in <= k;
		x_in <= x;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_key(input logic [255:0] key);
		drain();
		write_reg(REG_KEY_W0, key[63:0]);
		write_reg(REG_KEY_W1, key[127:64]);
		write_reg(REG_KEY_W2, key[191:128]);
		write_reg(REG_KEY_W3, key[255:192]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int count);
		logic [255:0] e;
		logic [255:0] k;
		logic [255:0] x;
		for (int i = 0; i < count; i++) begin
			e = pick_operand();
			k = pick_operand();
			x = pick_operand();
			// now and then aim r or k + r at zero mod n
			case ($urandom_range(9))
				0: x = ORD_N - (e % ORD_N);
				1: k = ORD_N - (((e % ORD_N) + (x % ORD_N)) % ORD_N);
				default: ;
			endcase
			send_word(e, k, x);
		end
	endtask

	initial begin
		logic [255:0] big_key;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key never written: s follows from r alone
		send_word('0, '0, '0);
		send_word('1, '1, '1);
		send_word(ORD_N, ORD_N, ORD_N);
		send_word(ORD_N - 1, 256'd1, ORD_N - 1);
		drain();

		load_key(256'd1);
		send_word('0, '0, '0);
		send_word('1, '1, '1);
		send_word(ORD_N, ORD_N, ORD_N);
		send_word(ORD_N - 1, ORD_N - 1, ORD_N - 1);
		send_word(256'd5, 256'd7, ORD_N - 5);
		send_word(256'd5, ORD_N - 10, 256'd5);
		send_word(ORD_N + 3, 256'd0, 256'd9);
		send_word(256'd1, '1, ORD_N + 1);

		load_key(ORD_N - 1);
		send_word('1, '1, '1);
		send_word(ORD_N - 1, ORD_N - 1, 256'd0);
		send_word(256'd1, 256'd0, 256'd0);
		send_word('0, ORD_N, '1);
		send_word(256'd3, ORD_N - 6, 256'd3);

		load_key('1);
		send_word('1, '1, '1);
		send_word(256'd2, 256'd0, ORD_N - 2);
		send_word(ORD_N - 1, ORD_N - 1, ORD_N - 1);
		run_random(130);

		send_idle_pct = 17;
		load_key(rand_wide() % ORD_N);
		run_random(150);
		load_key(ORD_N);
		run_random(120);

		send_idle_pct = 82;
		load_key(rand_wide());
		run_random(150);
		load_key('0);
		run_random(80);

		send_idle_pct = 0;
		big_key = rand_wide();
		load_key(big_key);
		run_random(150);
		load_key(big_key ^ {4{64'hFFFF0000FFFF0000}});
		run_random(100);

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
